// File: src/rgbwenc_pkg.sv
// Shared types and constants for the RGBW LED SPI bit encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rgbwenc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_ONE_CODE   = 2'd1;
  localparam logic [1:0] REG_ZERO_CODE  = 2'd2;
  localparam logic [1:0] REG_RESET_LEN  = 2'd3;

  // Register reset values
  localparam logic [7:0] BRIGHTNESS_RST = 8'd255;
  localparam logic [7:0] ONE_CODE_RST   = 8'd240;
  localparam logic [7:0] ZERO_CODE_RST  = 8'd192;
  localparam logic [8:0] RESET_LEN_RST  = 9'd64;

  // Longest reset run, in bytes
  localparam logic [8:0] MAX_RESET_BYTES = 9'd256;

  // Percent clamp
  localparam logic [7:0] PCT_MAX = 8'd100;

  // floor(x/100) = (x*RECIP_100) >> 22 for x < 43690
  localparam logic [15:0] RECIP_100 = 16'd41944;
  // floor(y/255) = (y*RECIP_255) >> 24 for y < 66052
  localparam logic [16:0] RECIP_255 = 17'd65794;
  // Rounding offset for the brightness scale
  localparam logic [15:0] ROUND_255 = 16'd128;

  // Bytes in one SPI word
  localparam logic [3:0] WORD_BYTES = 4'd8;

  // One pixel after scaling, channels in send order G, R, B, W
  typedef struct packed {
    logic [3:0][7:0] chan;
    logic [8:0]      rem;
  } rgbwenc_entry_t;

endpackage

`default_nettype wire

// File: src/rgbwenc_front.sv
// Front end: accepts pixels and scales each channel by percent and brightness.
// Four-stage lane pipeline; depends on rgbwenc_pkg.
`default_nettype none

module rgbwenc_front
  import rgbwenc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     red,
  input  wire logic [7:0]     green,
  input  wire logic [7:0]     blue,
  input  wire logic [7:0]     white,
  input  wire logic [7:0]     percent,
  input  wire logic           final_pixel,
  input  wire logic [7:0]     brightness,
  input  wire logic [8:0]     reset_len,
  output logic                push_valid,
  input  wire logic           push_ready,
  output rgbwenc_entry_t      push_data
);

  logic [3:0]       vld;
  logic             en;
  logic [3:0][7:0]  chan_in;
  logic [6:0]       pct_c;
  logic [8:0]       rem_in;

  logic [3:0][14:0] s1_prod;
  logic [3:0][7:0]  s2_val;
  logic [3:0][15:0] s3_sum;
  logic [3:0][7:0]  s4_val;
  logic [8:0]       s1_rem, s2_rem, s3_rem, s4_rem;

  logic [3:0][30:0] div100_prod;
  logic [3:0][32:0] div255_prod;

  // Advance the whole pipe unless the last stage is blocked by a full queue
  assign en         = !vld[3] || push_ready;
  assign in_ready   = en;
  assign push_valid = vld[3];
  assign push_data  = '{chan: s4_val, rem: s4_rem};

  // Reorder into send order and clamp controls
  always_comb begin
    chan_in[0] = green;
    chan_in[1] = red;
    chan_in[2] = blue;
    chan_in[3] = white;
    pct_c = (percent > PCT_MAX) ? PCT_MAX[6:0] : percent[6:0];
    if (!final_pixel) begin
      rem_in = '0;
    end else if (reset_len > MAX_RESET_BYTES) begin
      rem_in = MAX_RESET_BYTES;
    end else begin
      rem_in = reset_len;
    end
  end

  // Reciprocal multiplies for the two constant divisions
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      div100_prod[i] = 31'(s1_prod[i]) * 31'(RECIP_100);
      div255_prod[i] = 33'(s3_sum[i]) * 33'(RECIP_255);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // Lane datapath
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_prod[i] <= 15'(chan_in[i]) * 15'(pct_c);
        s2_val[i]  <= div100_prod[i][29:22];
        s3_sum[i]  <= 16'(s2_val[i]) * 16'(brightness) + ROUND_255;
        s4_val[i]  <= div255_prod[i][31:24];
      end
      s1_rem <= rem_in;
      s2_rem <= s1_rem;
      s3_rem <= s2_rem;
      s4_rem <= s3_rem;
    end
  end

endmodule

`default_nettype wire

// File: src/rgbwenc_queue.sv
// Short flop-based queue between the front end and the serializer.
// Holds scaled pixels; depends on rgbwenc_pkg.
`default_nettype none

module rgbwenc_queue
  import rgbwenc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire rgbwenc_entry_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output rgbwenc_entry_t      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rgbwenc_entry_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/rgbwenc_back.sv
// Back end: expands channels to SPI code bytes and appends reset words.
// One word per cycle into an output register while the receiver takes them; depends on rgbwenc_pkg.
`default_nettype none

module rgbwenc_back
  import rgbwenc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire rgbwenc_entry_t pop_data,
  input  wire logic [7:0]     one_code,
  input  wire logic [7:0]     zero_code,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [63:0]         spi_word,
  output logic [3:0]          byte_count,
  output logic                end_of_run
);

  logic            busy;
  logic [3:0][7:0] chan;
  logic [1:0]      idx;
  logic            in_rst;
  logic [8:0]      rem;

  logic [63:0]     word;
  logic [3:0]      count;
  logic [8:0]      rem_left;
  logic            done;
  logic            load;
  logic            fire;
  logic [7:0]      cur;

  // Build the next word
  always_comb begin
    cur      = chan[idx];
    word     = '0;
    count    = WORD_BYTES;
    rem_left = rem;
    done     = 1'b0;
    if (!in_rst) begin
      for (int i = 0; i < 8; i++) begin
        word[i*8 +: 8] = cur[i] ? one_code : zero_code;
      end
      done = (idx == 2'd3) && (rem == '0);
    end else begin
      count    = (rem > 9'(WORD_BYTES)) ? WORD_BYTES : rem[3:0];
      rem_left = rem - 9'(count);
      done     = (rem_left == '0);
    end
  end

  assign load      = !out_valid || out_ready;
  assign fire      = busy && load;
  assign pop_ready = !busy || (fire && done);

  // Sequence through channels, then reset words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      idx    <= '0;
      in_rst <= 1'b0;
    end else if (pop_valid && pop_ready) begin
      busy   <= 1'b1;
      idx    <= '0;
      in_rst <= 1'b0;
    end else if (fire) begin
      if (done) begin
        busy <= 1'b0;
      end else if (!in_rst) begin
        if (idx == 2'd3) begin
          in_rst <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // Pixel payload and remaining reset bytes
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      chan <= pop_data.chan;
      rem  <= pop_data.rem;
    end else if (fire && in_rst) begin
      rem <= rem_left;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      spi_word   <= word;
      byte_count <= count;
      end_of_run <= done;
    end
  end

endmodule

`default_nettype wire

// File: src/rgbw_led_spi_bit_encoder.sv
// RGBW addressable-LED SPI bit encoder: top level with configuration registers.
// Uses rgbwenc_pkg, rgbwenc_front, rgbwenc_queue and rgbwenc_back.
//
// Usage: pixels arrive on the s_ stream, one per beat; s_tdata carries red,
// green, blue, white and percent, s_tlast marks the last pixel of a frame.
// Each pixel gives four beats on the m_ stream (G, R, B, W), each a 64-bit
// word of eight SPI code bytes, first byte on top, with the valid byte count
// above it. After a last pixel, min(reset_len, 256) zero bytes follow
// in words of up to eight bytes. m_tlast marks the final beat caused by each pixel.
// Path: the first word of a pixel passes the four scaling stages, the
// queue, the serializer and the output reg before m_tvalid rises.
// Throughput: one output word per cycle while m_tready holds, the
// serializer setting the pace: four words per pixel, plus
// ceil(min(reset_len, 256)/8) reset words after a last pixel.
// The front keeps taking pixels while the queue has room, so a stalled
// receiver only holds the output register and the serializer; s_tready
// drops once the queue is full and the last scaling stage holds a pixel.
// Reset clears the pipe and queue and loads the register defaults
// (brightness 255, one code 240, zero code 192, reset length 64).
// Write configuration only while the block is idle.
`default_nettype none

module rgbw_led_spi_bit_encoder
  import rgbwenc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // red, green, blue, white, percent
  input  wire logic        s_tlast,   // final_pixel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // spi_word[63:0], byte_count[67:64], zero pad
  output logic             m_tlast,   // end_of_run
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  logic [7:0]     brightness;
  logic [7:0]     one_code;
  logic [7:0]     zero_code;
  logic [8:0]     reset_len;

  logic           push_valid, push_ready;
  rgbwenc_entry_t push_data;
  logic           pop_valid, pop_ready;
  rgbwenc_entry_t pop_data;
  logic [63:0]    spi_word;
  logic [3:0]     byte_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHTNESS_RST;
      one_code   <= ONE_CODE_RST;
      zero_code  <= ZERO_CODE_RST;
      reset_len  <= RESET_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: brightness <= cfg_data[7:0];
        REG_ONE_CODE:   one_code   <= cfg_data[7:0];
        REG_ZERO_CODE:  zero_code  <= cfg_data[7:0];
        REG_RESET_LEN:  reset_len  <= cfg_data;
        default:        ;
      endcase
    end
  end

  rgbwenc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .red         (s_tdata[7:0]),
    .green       (s_tdata[15:8]),
    .blue        (s_tdata[23:16]),
    .white       (s_tdata[31:24]),
    .percent     (s_tdata[39:32]),
    .final_pixel (s_tlast),
    .brightness  (brightness),
    .reset_len   (reset_len),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  rgbwenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rgbwenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .one_code   (one_code),
    .zero_code  (zero_code),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .spi_word   (spi_word),
    .byte_count (byte_count),
    .end_of_run (m_tlast)
  );

  assign m_tdata = {4'b0000, byte_count, spi_word};

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for rgbw_led_spi_bit_encoder: streams pixels in, checks every SPI beat.
// Needs rgbwenc_pkg and the encoder RTL; predicts each beat from its own copy of the registers.
module tb_top;
  import rgbwenc_pkg::*;

  localparam int RUN_LIMIT    = 5_000_000;
  localparam int STALL_AT     = 40;
  localparam int STALL_CYCLES = 200;
  localparam int RESET_CAP    = 256;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic [7:0] percent;
    logic       final_pixel;
  } pixel_t;

  typedef struct {
    logic [63:0] spi_word;
    logic [3:0]  byte_count;
    logic        end_of_run;
  } spi_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // red, green, blue, white, percent
  logic        s_tlast = 1'b0; // final_pixel
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // spi_word[63:0], byte_count[67:64], zero pad
  logic        m_tlast;        // end_of_run
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BRIGHTNESS;
  logic [8:0]  cfg_data = '0;

  // Register shadow used by the predictor
  logic [7:0] bright_reg    = BRIGHTNESS_RST;
  logic [7:0] one_code_reg  = ONE_CODE_RST;
  logic [7:0] zero_code_reg = ZERO_CODE_RST;
  logic [8:0] reset_len_reg = RESET_LEN_RST;

  pixel_t    pixel_q[$];
  spi_beat_t spi_beats_due[$];
  pixel_t    pixel_on_bus;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        pixels_accepted = 0;
  int        stall_left = 0;
  bit        stall_seen = 1'b0;
  int        fail_count = 0;

  rgbw_led_spi_bit_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dim by percent (clamped, truncating), then apply brightness with rounding
  function automatic logic [7:0] scale_channel(logic [7:0] c, logic [7:0] pct);
    int unsigned p;
    int unsigned v;
    p = (pct > 8'd100) ? 100 : int'(pct);
    v = (int'(c) * p) / 100;
    if (bright_reg != 8'hFF) v = (v * int'(bright_reg) + 128) / 255;
    return v[7:0];
  endfunction

  // Map each data bit, MSB first, to a code byte
  function automatic logic [63:0] spi_expand(logic [7:0] v);
    logic [63:0] w;
    w = '0;
    for (int i = 7; i >= 0; i--) w = {w[55:0], v[i] ? one_code_reg : zero_code_reg};
    return w;
  endfunction

  // Queue the beats one accepted pixel should produce
  task automatic encode_pixel(pixel_t px);
    logic [7:0] chan[4];
    int         rem;
    int         n;
    spi_beat_t  b;
    chan[0] = px.green;
    chan[1] = px.red;
    chan[2] = px.blue;
    chan[3] = px.white;
    rem = px.final_pixel ? int'(reset_len_reg) : 0;
    if (rem > RESET_CAP) rem = RESET_CAP;
    for (int i = 0; i < 4; i++) begin
      b.spi_word   = spi_expand(scale_channel(chan[i], px.percent));
      b.byte_count = WORD_BYTES;
      b.end_of_run = (i == 3) && (rem == 0);
      spi_beats_due.push_back(b);
    end
    while (rem > 0) begin
      n = (rem > 8) ? 8 : rem;
      rem -= n;
      b.spi_word   = '0;
      b.byte_count = n[3:0];
      b.end_of_run = (rem == 0);
      spi_beats_due.push_back(b);
    end
  endtask

  // Driver: predict on accept, then offer the next pixel or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_pixel(pixel_on_bus);
        pixels_accepted <= pixels_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pixel_on_bus = pixel_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {pixel_on_bus.percent, pixel_on_bus.white, pixel_on_bus.blue,
                       pixel_on_bus.green, pixel_on_bus.red};
          s_tlast  <= pixel_on_bus.final_pixel;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps pushing
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_seen && pixels_accepted == STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_seen <= 1'b1;
    end
  end

  // Monitor: check each accepted beat against the oldest prediction
  always @(posedge clk) begin
    spi_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (spi_beats_due.size() == 0) begin
          $error("unexpected beat: spi_word %h byte_count %0d end_of_run %0d",
                 m_tdata[63:0], m_tdata[67:64], m_tlast);
          fail_count++;
        end else begin
          want = spi_beats_due.pop_front();
          if (m_tdata[63:0] !== want.spi_word) begin
            $error("spi_word: expected %h, got %h", want.spi_word, m_tdata[63:0]);
            fail_count++;
          end
          if (m_tdata[67:64] !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, m_tdata[67:64]);
            fail_count++;
          end
          if (m_tlast !== want.end_of_run) begin
            $error("end_of_run: expected %0d, got %0d", want.end_of_run, m_tlast);
            fail_count++;
          end
        end
      end
      m_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] w,
                             logic [7:0] pct, logic fin);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.white = w;
    px.percent = pct;
    px.final_pixel = fin;
    pixel_q.push_back(px);
  endtask

  // Mostly in-range percents, some above the clamp; frames end now and then
  task automatic queue_random_pixels(int count);
    logic [7:0] pct;
    for (int k = 0; k < count; k++) begin
      pct = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(101, 255))
                                        : 8'($urandom_range(0, 100));
      queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), pct,
                  $urandom_range(0, 7) == 0);
    end
  endtask

  // Write all four registers back to back, then drop the enable
  task automatic apply_settings(logic [7:0] br, logic [7:0] one, logic [7:0] zero,
                                logic [8:0] rlen);
    logic [8:0] vals[4];
    vals[0] = {1'b0, br};
    vals[1] = {1'b0, one};
    vals[2] = {1'b0, zero};
    vals[3] = rlen;
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
    end
    bright_reg    = br;
    one_code_reg  = one;
    zero_code_reg = zero;
    reset_len_reg = rlen;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_settings();
    logic [7:0] br;
    logic [8:0] rlen;
    case ($urandom_range(0, 3))
      0: br = 8'd0;
      1: br = 8'd255;
      default: br = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 5))
      0: rlen = 9'd0;
      1: rlen = 9'd256;
      2: rlen = 9'd511;
      default: rlen = 9'($urandom_range(1, 40));
    endcase
    apply_settings(br, 8'($urandom), 8'($urandom), rlen);
  endtask

  // Hold until every queued pixel went out and every beat came back
  task automatic wait_drained();
    while (pixel_q.size() != 0 || s_tvalid || spi_beats_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 88;

    // Channel extremes and percent clamp under the default registers
    apply_settings(BRIGHTNESS_RST, ONE_CODE_RST, ZERO_CODE_RST, RESET_LEN_RST);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'd100, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd100, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd101, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255, 1'b0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd25, 8'd50, 1'b0);
    queue_pixel(8'h12, 8'h34, 8'h56, 8'h78, 8'd100, 1'b1);
    queue_pixel(8'h80, 8'h01, 8'hFF, 8'h7F, 8'd99, 1'b0);
    wait_drained();

    // Zero brightness, no reset run after a last pixel
    apply_settings(8'd0, 8'hFF, 8'h00, 9'd0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd100, 1'b1);
    queue_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'd100, 1'b0);
    queue_pixel(8'h01, 8'h02, 8'h04, 8'h08, 8'd77, 1'b1);
    wait_drained();

    // Half brightness, reset run ending in a short word
    apply_settings(8'd128, 8'hAA, 8'h55, 9'd13);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd100, 1'b1);
    queue_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'd100, 1'b0);
    queue_pixel(8'h80, 8'h40, 8'h20, 8'h10, 8'd100, 1'b1);
    wait_drained();

    // Reset length above the cap saturates
    apply_settings(8'd1, 8'h00, 8'hFF, 9'd511);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd100, 1'b1);
    queue_pixel(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 1'b1);
    wait_drained();

    // Reset length exactly at the cap
    apply_settings(8'd254, 8'h0F, 8'hF0, 9'd256);
    queue_pixel(8'hFF, 8'hFE, 8'h7F, 8'h01, 8'd100, 1'b0);
    queue_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'd100, 1'b1);
    wait_drained();

    // Random frames: slow receiver, then slow sender, then full speed
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 11; recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      randomize_settings();
      queue_random_pixels(40);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && spi_beats_due.size() == 0) begin
      $display("rgbw_led_spi_bit_encoder: match");
    end else begin
      $display("rgbw_led_spi_bit_encoder: mismatch");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("rgbw_led_spi_bit_encoder: mismatch");
    $finish;
  end

endmodule
